>>> hdl/pfs_pkg.sv
package pfs_pkg;

   // Request modes.
   localparam logic [2:0] ModePutValue  = 3'd0;
   localparam logic [2:0] ModePutBits   = 3'd1;
   localparam logic [2:0] ModeEnterBits = 3'd2;
   localparam logic [2:0] ModeLeaveBits = 3'd3;
   localparam logic [2:0] ModeSeek      = 3'd4;

   // Result status codes.
   localparam logic [1:0] StatusOk     = 2'd0;
   localparam logic [1:0] StatusNoRoom = 2'd1;
   localparam logic [1:0] StatusBadReq = 2'd2;

   // Byte orders.
   localparam logic [1:0] OrderBig    = 2'd0;
   localparam logic [1:0] OrderLittle = 2'd1;
   localparam logic [1:0] OrderMidA   = 2'd2;
   localparam logic [1:0] OrderMidB   = 2'd3;

   typedef struct packed {
      logic [2:0]  mode;
      logic [63:0] value;
      logic [3:0]  byte_count;
      logic [5:0]  bit_count;
      logic [1:0]  byte_order;
      logic        negate;
      logic        invert_128;
      logic        offset_128;
      logic [15:0] position;
   } req_type;

   typedef struct packed {
      logic [7:0]  out_byte;
      logic [15:0] byte_offset;
      logic        byte_valid;
      logic [1:0]  status;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic step;
   } shift_ctrl_type;

   typedef struct packed {
      logic load;
      logic step;
      logic clear;
   } pack_ctrl_type;

   typedef struct packed {
      logic [2:0] bit_index;
      logic [7:0] partial;
      logic [7:0] cur_byte;
      logic       last_bit;
   } pack_stat_type;

endpackage

>>> hdl/pfs_channels.sv
interface pfs_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  mode;
   logic [63:0] value;
   logic [3:0]  byte_count;
   logic [5:0]  bit_count;
   logic [1:0]  byte_order;
   logic        negate;
   logic        invert_128;
   logic        offset_128;
   logic [15:0] position;

   modport source (
      output valid, mode, value, byte_count, bit_count, byte_order,
             negate, invert_128, offset_128, position,
      input  ready
   );
   modport sink (
      input  valid, mode, value, byte_count, bit_count, byte_order,
             negate, invert_128, offset_128, position,
      output ready
   );
endinterface

interface pfs_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  out_byte;
   logic [15:0] byte_offset;
   logic        byte_valid;
   logic [1:0]  status;
   logic        last;

   modport source (
      output valid, out_byte, byte_offset, byte_valid, status, last,
      input  ready
   );
   modport sink (
      input  valid, out_byte, byte_offset, byte_valid, status, last,
      output ready
   );
endinterface

>>> hdl/packet_field_serializer.sv
// Channel   Direction  Handshake        Payload
// req_chan  in         valid / ready    mode, value, byte_count, bit_count, byte_order,
//                                       negate, invert_128, offset_128, position
// rsp_chan  out        valid / ready    out_byte, byte_offset, byte_valid, status, last
// csr_*     in         write enable     buffer_length (16 bits)
//
// A value put takes the beat, checks it, and then sends one byte a cycle out of the byte
// shift register while the result channel is free. A bit put places one bit per cycle
// in the bit packer unless a beat it owes finds no free slot; others answer with one beat.
// Reset is synchronous and leaves the block ready in the next cycle; there is no clearing pass.
// A stalled result channel holds the machine at the next beat it must send; the beat that
// waits in the output register does not stop the next request from being taken.
module packet_field_serializer #(
   parameter int unsigned MAX_LENGTH = 65535
) (
   input  logic        clock,
   input  logic        reset,
   pfs_req_if.sink     req_chan,
   pfs_rsp_if.source   rsp_chan,
   input  logic        csr_write_enable,
   input  logic [15:0] csr_write_data
);

   // The usable buffer length is clamped once, when the register is written.
   localparam logic [15:0] MaxLen = 16'(MAX_LENGTH);

   localparam logic [1:0] StIdle   = 2'd0;
   localparam logic [1:0] StDecide = 2'd1;
   localparam logic [1:0] StBytes  = 2'd2;
   localparam logic [1:0] StBits   = 2'd3;

   logic [1:0]              state_ff, state_in;
   logic [15:0]             len_ff, len_in;
   logic [16:0]             wp_ff, wp_in;
   logic                    bit_mode_ff, bit_mode_in;
   logic [2:0]              bytes_left_ff, bytes_left_in;
   logic                    no_bytes_ff, no_bytes_in;
   pfs_pkg::req_type        req_ff, req_in;

   pfs_pkg::shift_ctrl_type shift_ctrl;
   pfs_pkg::pack_ctrl_type  pack_ctrl;
   pfs_pkg::pack_stat_type  pack_stat;
   pfs_pkg::rsp_type        rsp_data;
   logic                    rsp_load;
   logic                    out_free;
   logic [7:0]              shift_byte;
   logic                    shift_last;

   logic                    count_ok;
   logic                    value_fit;
   logic                    bits_ok;
   logic [6:0]              used;
   logic [2:0]              touched;
   logic [2:0]              done_bytes;
   logic                    bits_fit;
   logic                    leave_fit;
   logic                    start;
   logic                    emit_byte;
   logic                    emit_status;

   pfs_byte_shifter u_shifter (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (shift_ctrl),
      .req      (req_ff),
      .out_byte (shift_byte),
      .last     (shift_last)
   );

   pfs_bit_packer u_packer (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (pack_ctrl),
      .load_bits  (req_ff.value[31:0]),
      .load_count (req_ff.bit_count),
      .stat       (pack_stat)
   );

   pfs_rsp_stage u_rsp (
      .clock    (clock),
      .reset    (reset),
      .load     (rsp_load),
      .data     (rsp_data),
      .free     (out_free),
      .rsp_chan (rsp_chan)
   );

   assign req_chan.ready = (state_ff == StIdle);

   always_comb begin
      len_in = len_ff;
      if (csr_write_enable) begin
         len_in = (csr_write_data < MaxLen) ? csr_write_data : MaxLen;
      end
   end

   // Checks for the request held in req_ff. A bit put touches the current partial byte
   // plus the bits it adds, rounded up to whole bytes.
   always_comb begin
      count_ok   = (req_ff.byte_count == 4'd1) || (req_ff.byte_count == 4'd2) ||
                   (req_ff.byte_count == 4'd3) || (req_ff.byte_count == 4'd4) ||
                   (req_ff.byte_count == 4'd8);
      value_fit  = ({1'b0, wp_ff} + 18'(req_ff.byte_count)) <= {2'b00, len_ff};
      bits_ok    = (req_ff.bit_count != 6'd0) && (req_ff.bit_count <= 6'd32);
      used       = 7'(3'd7 - pack_stat.bit_index) + 7'(req_ff.bit_count);
      touched    = 3'((used + 7'd7) >> 3);
      done_bytes = 3'(used >> 3);
      bits_fit   = ({1'b0, wp_ff} + 18'(touched)) <= {2'b00, len_ff};
      leave_fit  = wp_ff < {1'b0, len_ff};
   end

   always_comb begin
      state_in      = state_ff;
      wp_in         = wp_ff;
      bit_mode_in   = bit_mode_ff;
      bytes_left_in = bytes_left_ff;
      no_bytes_in   = no_bytes_ff;
      req_in        = req_ff;
      shift_ctrl    = '0;
      pack_ctrl     = '0;
      rsp_load      = 1'b0;
      start         = 1'b0;
      emit_byte     = 1'b0;
      emit_status   = 1'b0;

      rsp_data.out_byte    = 8'd0;
      rsp_data.byte_offset = wp_ff[15:0];
      rsp_data.byte_valid  = 1'b0;
      rsp_data.status      = pfs_pkg::StatusOk;
      rsp_data.last        = 1'b1;

      unique case (state_ff)
         StIdle: begin
            if (req_chan.valid) begin
               req_in.mode       = req_chan.mode;
               req_in.value      = req_chan.value;
               req_in.byte_count = req_chan.byte_count;
               req_in.bit_count  = req_chan.bit_count;
               req_in.byte_order = req_chan.byte_order;
               req_in.negate     = req_chan.negate;
               req_in.invert_128 = req_chan.invert_128;
               req_in.offset_128 = req_chan.offset_128;
               req_in.position   = req_chan.position;
               state_in          = StDecide;
            end
         end

         StDecide: begin
            unique case (req_ff.mode)
               pfs_pkg::ModePutValue: begin
                  if (bit_mode_ff || !count_ok) begin
                     rsp_data.status = pfs_pkg::StatusBadReq;
                  end else if (!value_fit) begin
                     rsp_data.status = pfs_pkg::StatusNoRoom;
                  end else begin
                     start           = 1'b1;
                     shift_ctrl.load = 1'b1;
                     state_in        = StBytes;
                  end
               end
               pfs_pkg::ModePutBits: begin
                  if (!bit_mode_ff || !bits_ok) begin
                     rsp_data.status = pfs_pkg::StatusBadReq;
                  end else if (!bits_fit) begin
                     rsp_data.status = pfs_pkg::StatusNoRoom;
                  end else begin
                     start          = 1'b1;
                     pack_ctrl.load = 1'b1;
                     bytes_left_in  = done_bytes;
                     no_bytes_in    = (done_bytes == 3'd0);
                     state_in       = StBits;
                  end
               end
               pfs_pkg::ModeEnterBits: begin
                  if (!bit_mode_ff) begin
                     bit_mode_in     = 1'b1;
                     pack_ctrl.clear = 1'b1;
                  end
               end
               pfs_pkg::ModeLeaveBits: begin
                  if (bit_mode_ff) begin
                     // A pending partial byte goes out zero-padded if there is room.
                     if (pack_stat.bit_index != 3'd7) begin
                        if (leave_fit) begin
                           rsp_data.out_byte   = pack_stat.partial;
                           rsp_data.byte_valid = 1'b1;
                           wp_in               = wp_ff + 17'd1;
                        end else begin
                           rsp_data.status = pfs_pkg::StatusNoRoom;
                        end
                     end
                     bit_mode_in     = 1'b0;
                     pack_ctrl.clear = 1'b1;
                  end
               end
               pfs_pkg::ModeSeek: begin
                  if (req_ff.position > len_ff) begin
                     rsp_data.status = pfs_pkg::StatusBadReq;
                  end else begin
                     wp_in                = {1'b0, req_ff.position};
                     rsp_data.byte_offset = req_ff.position;
                  end
               end
               default: begin
                  rsp_data.status = pfs_pkg::StatusBadReq;
               end
            endcase

            // Requests that answer with a single beat commit only when that beat has a slot.
            if (!start) begin
               if (out_free) begin
                  rsp_load = 1'b1;
                  state_in = StIdle;
               end else begin
                  wp_in           = wp_ff;
                  bit_mode_in     = bit_mode_ff;
                  pack_ctrl.clear = 1'b0;
               end
            end
         end

         StBytes: begin
            rsp_data.out_byte   = shift_byte;
            rsp_data.byte_valid = 1'b1;
            rsp_data.last       = shift_last;
            if (out_free) begin
               shift_ctrl.step = 1'b1;
               rsp_load        = 1'b1;
               wp_in           = wp_ff + 17'd1;
               if (shift_last) begin
                  state_in = StIdle;
               end
            end
         end

         StBits: begin
            // A bit that completes a byte sends it; a put that completes no byte
            // reports a plain status beat on its final bit.
            emit_byte   = (pack_stat.bit_index == 3'd0);
            emit_status = pack_stat.last_bit && no_bytes_ff;
            if (emit_byte) begin
               rsp_data.out_byte   = pack_stat.cur_byte;
               rsp_data.byte_valid = 1'b1;
               rsp_data.last       = (bytes_left_ff == 3'd1);
            end
            if (!(emit_byte || emit_status) || out_free) begin
               pack_ctrl.step = 1'b1;
               rsp_load       = emit_byte || emit_status;
               if (emit_byte) begin
                  wp_in         = wp_ff + 17'd1;
                  bytes_left_in = bytes_left_ff - 3'd1;
               end
               if (pack_stat.last_bit) begin
                  state_in = StIdle;
               end
            end
         end

         default: begin
            state_in = StIdle;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      req_ff        <= req_in;
      bytes_left_ff <= bytes_left_in;
      no_bytes_ff   <= no_bytes_in;
      if (reset) begin
         state_ff    <= StIdle;
         len_ff      <= MaxLen;
         wp_ff       <= 17'd0;
         bit_mode_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         len_ff      <= len_in;
         wp_ff       <= wp_in;
         bit_mode_ff <= bit_mode_in;
      end
   end

endmodule

>>> hdl/pfs_byte_shifter.sv
module pfs_byte_shifter (
   input  logic                    clock,
   input  logic                    reset,
   input  pfs_pkg::shift_ctrl_type ctrl,
   input  pfs_pkg::req_type        req,
   output logic [7:0]              out_byte,
   output logic                    last
);

   logic [63:0] data_ff, data_in;
   logic [3:0]  count_ff, count_in;
   logic [63:0] word;
   logic [63:0] little;
   logic [63:0] arranged;
   logic [7:0]  lo;

   // Low byte adjustments are applied in a fixed order.
   always_comb begin
      lo = req.value[7:0];
      if (req.negate) begin
         lo = 8'd0 - lo;
      end
      if (req.invert_128) begin
         lo = 8'd128 - lo;
      end
      if (req.offset_128) begin
         lo = lo + 8'd128;
      end
      word = {req.value[63:8], lo};
   end

   // The first byte to go out sits in the top byte of the shift register.
   always_comb begin
      for (int k = 0; k < 8; k++) begin
         little[63 - 8 * k -: 8] = word[8 * k +: 8];
      end
   end

   always_comb begin
      if (req.byte_count == 4'd4 && req.byte_order == pfs_pkg::OrderMidA) begin
         arranged = {word[23:16], word[31:24], word[7:0], word[15:8], 32'd0};
      end else if (req.byte_count == 4'd4 && req.byte_order == pfs_pkg::OrderMidB) begin
         arranged = {word[15:8], word[7:0], word[31:24], word[23:16], 32'd0};
      end else if (req.byte_order == pfs_pkg::OrderLittle) begin
         arranged = little;
      end else begin
         unique case (req.byte_count)
            4'd1:    arranged = {word[7:0], 56'd0};
            4'd2:    arranged = {word[15:0], 48'd0};
            4'd3:    arranged = {word[23:0], 40'd0};
            4'd4:    arranged = {word[31:0], 32'd0};
            default: arranged = word;
         endcase
      end
   end

   always_comb begin
      data_in  = data_ff;
      count_in = count_ff;
      if (ctrl.load) begin
         data_in  = arranged;
         count_in = req.byte_count;
      end else if (ctrl.step) begin
         data_in  = {data_ff[55:0], 8'd0};
         count_in = count_ff - 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      if (reset) begin
         count_ff <= 4'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign out_byte = data_ff[63:56];
   assign last     = (count_ff == 4'd1);

endmodule

>>> hdl/pfs_bit_packer.sv
module pfs_bit_packer (
   input  logic                   clock,
   input  logic                   reset,
   input  pfs_pkg::pack_ctrl_type ctrl,
   input  logic [31:0]            load_bits,
   input  logic [5:0]             load_count,
   output pfs_pkg::pack_stat_type stat
);

   logic [31:0] bits_ff, bits_in;
   logic [5:0]  left_ff, left_in;
   logic [2:0]  bit_index_ff, bit_index_in;
   logic [7:0]  partial_ff, partial_in;
   logic [7:0]  mask;
   logic [7:0]  merged;

   // The next bit to place is always the top bit of the shift register.
   always_comb begin
      mask   = 8'd1 << bit_index_ff;
      merged = bits_ff[31] ? (partial_ff | mask) : (partial_ff & ~mask);
   end

   always_comb begin
      bits_in      = bits_ff;
      left_in      = left_ff;
      bit_index_in = bit_index_ff;
      partial_in   = partial_ff;
      if (ctrl.clear) begin
         bit_index_in = 3'd7;
         partial_in   = 8'd0;
      end else if (ctrl.load) begin
         bits_in = load_bits << (6'd32 - load_count);
         left_in = load_count;
      end else if (ctrl.step) begin
         bits_in = {bits_ff[30:0], 1'b0};
         left_in = left_ff - 6'd1;
         if (bit_index_ff == 3'd0) begin
            bit_index_in = 3'd7;
            partial_in   = 8'd0;
         end else begin
            bit_index_in = bit_index_ff - 3'd1;
            partial_in   = merged;
         end
      end
   end

   always_ff @(posedge clock) begin
      bits_ff <= bits_in;
      if (reset) begin
         left_ff      <= 6'd0;
         bit_index_ff <= 3'd7;
         partial_ff   <= 8'd0;
      end else begin
         left_ff      <= left_in;
         bit_index_ff <= bit_index_in;
         partial_ff   <= partial_in;
      end
   end

   assign stat.bit_index = bit_index_ff;
   assign stat.partial   = partial_ff;
   assign stat.cur_byte  = merged;
   assign stat.last_bit  = (left_ff == 6'd1);

endmodule

>>> hdl/pfs_rsp_stage.sv
module pfs_rsp_stage (
   input  logic             clock,
   input  logic             reset,
   input  logic             load,
   input  pfs_pkg::rsp_type data,
   output logic             free,
   pfs_rsp_if.source        rsp_chan
);

   logic             valid_ff, valid_in;
   pfs_pkg::rsp_type data_ff;

   assign free = !valid_ff || rsp_chan.ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= data;
      end
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign rsp_chan.valid       = valid_ff;
   assign rsp_chan.out_byte    = data_ff.out_byte;
   assign rsp_chan.byte_offset = data_ff.byte_offset;
   assign rsp_chan.byte_valid  = data_ff.byte_valid;
   assign rsp_chan.status      = data_ff.status;
   assign rsp_chan.last        = data_ff.last;

endmodule

>>> hdl/pfs_checker.sv
module pfs_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [7:0]  rsp_out_byte,
   input logic [15:0] rsp_byte_offset,
   input logic        rsp_byte_valid,
   input logic [1:0]  rsp_status,
   input logic        rsp_last
);

   // A stalled beat keeps its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte) &&
         $stable(rsp_byte_offset) && $stable(rsp_byte_valid) && $stable(rsp_last))
      else $error("result beat changed while stalled");

   // Data beats always report success.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_byte_valid |-> rsp_status == pfs_pkg::StatusOk)
      else $error("data beat with a failure status");

   // A status-only beat is the sole answer to its request.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_byte_valid |-> rsp_last)
      else $error("status beat not marked last");

   // The block is ready for a request right after reset.
   assert property (@(posedge clock)
      reset |=> req_ready && !rsp_valid)
      else $error("not ready after reset");

endmodule

bind packet_field_serializer pfs_checker u_pfs_checker (
   .clock           (clock),
   .reset           (reset),
   .req_ready       (req_chan.ready),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_out_byte    (rsp_chan.out_byte),
   .rsp_byte_offset (rsp_chan.byte_offset),
   .rsp_byte_valid  (rsp_chan.byte_valid),
   .rsp_status      (rsp_chan.status),
   .rsp_last        (rsp_chan.last)
);

>>> tb/sv/testbench.sv
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import pfs_pkg::*;

   // Modes that the block does not implement; they must come back as bad requests.
   localparam logic [2:0] ModeFirstUnused = 3'd5;
   localparam logic [2:0] ModeLastUnused  = 3'd7;

   // One row of the directed table. When typed is set, the row carries its single
   // expected beat by hand and that beat replaces what the predictor works out.
   typedef struct {
      req_type req;
      bit      typed;
      rsp_type beat;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        csr_write_enable;
   logic [15:0] csr_write_data;

   pfs_req_if req_chan ();
   pfs_rsp_if rsp_chan ();

   packet_field_serializer dut (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_chan),
      .rsp_chan         (rsp_chan),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   // Free-running 4 ns clock.
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Our own copy of the serializer state and of its one register. The write
   // position is 17 bits wide, as in the block, so that it can sit one past the
   // last offset without wrapping.
   logic [16:0] wr_pos      = '0;
   logic        bits_on     = 1'b0;
   logic [2:0]  bit_idx     = 3'd7;
   logic [7:0]  partial     = '0;
   logic [15:0] buf_len     = 16'hFFFF;

   rsp_type      beats_for_request [$];   // beats that the request being predicted causes
   rsp_type      expected_beats [$];      // every beat still owed by the block, oldest first
   stim_row_type directed_rows [$];

   int          mismatch_count  = 0;
   int          burst_left      = 0;
   bit          hold_off_request = 1'b0;

   // ---------------------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------------------

   function automatic rsp_type status_beat(logic [15:0] offset, logic [1:0] st);
      rsp_type b;
      b.out_byte    = '0;
      b.byte_offset = offset;
      b.byte_valid  = 1'b0;
      b.status      = st;
      b.last        = 1'b1;
      return b;
   endfunction

   // A data byte always lands at the current write position, which then moves on.
   function automatic void emit_data_byte(logic [7:0] data);
      rsp_type b;
      b.out_byte    = data;
      b.byte_offset = wr_pos[15:0];
      b.byte_valid  = 1'b1;
      b.status      = StatusOk;
      b.last        = 1'b0;
      beats_for_request.push_back(b);
      wr_pos = wr_pos + 17'd1;
   endfunction

   function automatic logic [1:0] predict_value_put(req_type r);
      logic [7:0] b [8];
      logic [7:0] lo;
      int         n;
      int         k;
      n = r.byte_count;
      if (bits_on) return StatusBadReq;
      if (!(n inside {1, 2, 3, 4, 8})) return StatusBadReq;
      if (int'(wr_pos) + n > int'(buf_len)) return StatusNoRoom;
      for (k = 0; k < 8; k++) b[k] = r.value[8*k +: 8];
      // The three byte adjustments apply in a fixed order, each modulo 256.
      lo = b[0];
      if (r.negate)     lo = 8'd0 - lo;
      if (r.invert_128) lo = 8'd128 - lo;
      if (r.offset_128) lo = lo + 8'd128;
      b[0] = lo;
      if (n == 4 && r.byte_order == OrderMidA) begin
         emit_data_byte(b[2]);
         emit_data_byte(b[3]);
         emit_data_byte(b[0]);
         emit_data_byte(b[1]);
      end else if (n == 4 && r.byte_order == OrderMidB) begin
         emit_data_byte(b[1]);
         emit_data_byte(b[0]);
         emit_data_byte(b[3]);
         emit_data_byte(b[2]);
      end else if (r.byte_order == OrderLittle) begin
         for (k = 0; k < n; k++) emit_data_byte(b[k]);
      end else begin
         // Middle orders on widths other than four fall back to big order.
         for (k = n - 1; k >= 0; k--) emit_data_byte(b[k]);
      end
      return StatusOk;
   endfunction

   function automatic logic [1:0] predict_bit_put(req_type r);
      int          nb;
      int          touched;
      int          k;
      logic [31:0] v;
      nb = r.bit_count;
      v  = r.value[31:0];
      if (!bits_on || nb == 0 || nb > 32) return StatusBadReq;
      // The byte being filled counts as touched, so a put that only adds bits to
      // it still needs room for it.
      touched = ((7 - int'(bit_idx)) + nb + 7) / 8;
      if (int'(wr_pos) + touched > int'(buf_len)) return StatusNoRoom;
      for (k = nb; k > 0; k--) begin
         partial[bit_idx] = v[k-1];
         if (bit_idx == 3'd0) begin
            emit_data_byte(partial);
            partial = '0;
            bit_idx = 3'd7;
         end else begin
            bit_idx = bit_idx - 3'd1;
         end
      end
      return StatusOk;
   endfunction

   function automatic void predict_serializer_step(req_type r);
      logic [1:0] st;
      rsp_type    tail;
      st = StatusOk;
      beats_for_request.delete();
      case (r.mode)
         ModePutValue: st = predict_value_put(r);
         ModePutBits:  st = predict_bit_put(r);
         ModeEnterBits: begin
            if (!bits_on) begin
               bits_on = 1'b1;
               bit_idx = 3'd7;
               partial = '0;
            end
         end
         ModeLeaveBits: begin
            if (bits_on) begin
               // A pending partial byte goes out zero padded if it still fits;
               // otherwise it is dropped, but bit mode ends either way.
               if (bit_idx != 3'd7) begin
                  if (int'(wr_pos) < int'(buf_len)) emit_data_byte(partial);
                  else st = StatusNoRoom;
               end
               partial = '0;
               bit_idx = 3'd7;
               bits_on = 1'b0;
            end
         end
         ModeSeek: begin
            if (r.position > buf_len) st = StatusBadReq;
            else wr_pos = {1'b0, r.position};
         end
         default: st = StatusBadReq;
      endcase
      if (beats_for_request.size() == 0)
         beats_for_request.push_back(status_beat(wr_pos[15:0], st));
      tail = beats_for_request.pop_back();
      tail.last = 1'b1;
      beats_for_request.push_back(tail);
   endfunction

   // ---------------------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------------------

   function automatic req_type make_req(logic [2:0] mode, logic [63:0] value,
                                        logic [3:0] nbytes, logic [5:0] nbits,
                                        logic [1:0] order, logic [2:0] adjust,
                                        logic [15:0] pos);
      req_type r;
      r.mode       = mode;
      r.value      = value;
      r.byte_count = nbytes;
      r.bit_count  = nbits;
      r.byte_order = order;
      r.negate     = adjust[2];
      r.invert_128 = adjust[1];
      r.offset_128 = adjust[0];
      r.position   = pos;
      return r;
   endfunction

   task automatic add_row(input req_type r, input bit typed, input rsp_type beat);
      stim_row_type row;
      row.req   = r;
      row.typed = typed;
      row.beat  = beat;
      directed_rows.push_back(row);
   endtask

   // Every field fully random, so that every bit of every field gets exercised;
   // callers then pin down the fields that shape the request.
   function automatic req_type random_req();
      req_type r;
      r.mode       = 3'($urandom_range(0, 7));
      r.value      = {$urandom, $urandom};
      r.byte_count = 4'($urandom);
      r.bit_count  = 6'($urandom);
      r.byte_order = 2'($urandom);
      r.negate     = 1'($urandom);
      r.invert_128 = 1'($urandom);
      r.offset_128 = 1'($urandom);
      r.position   = 16'($urandom);
      return r;
   endfunction

   // Seek targets fall mostly anywhere in the buffer, often near its end, where the room
   // checks bite, and now and then anywhere in the 16-bit range, which with a short buffer
   // lands beyond its end.
   function automatic logic [15:0] seek_target();
      case ($urandom_range(0, 3))
         0: return 16'($urandom);
         1: return (buf_len > 16'd8) ? buf_len - 16'($urandom_range(0, 8))
                                     : 16'($urandom_range(0, 8));
         default: return 16'($urandom_range(0, buf_len));
      endcase
   endfunction

   // Sender side of the request channel. Requests go out in bursts of random
   // length; between bursts valid drops for a random number of cycles, or not at
   // all. Long bursts now and then give stretches with no idling. Payload and
   // valid change only at the falling edge; the handshake is sampled at the
   // rising edge, and the prediction is made for the beat at the edge that
   // takes it.
   task automatic send_request(input req_type r, input bit typed, input rsp_type fixed);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 5);
         if (gap != 0) begin
            req_chan.valid = 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = ($urandom_range(0, 5) == 0) ? 48 : $urandom_range(1, 10);
      end
      burst_left--;
      req_chan.mode       = r.mode;
      req_chan.value      = r.value;
      req_chan.byte_count = r.byte_count;
      req_chan.bit_count  = r.bit_count;
      req_chan.byte_order = r.byte_order;
      req_chan.negate     = r.negate;
      req_chan.invert_128 = r.invert_128;
      req_chan.offset_128 = r.offset_128;
      req_chan.position   = r.position;
      req_chan.valid      = 1'b1;
      do @(posedge clock); while (!req_chan.ready);
      predict_serializer_step(r);
      if (typed) begin
         expected_beats.push_back(fixed);
      end else begin
         foreach (beats_for_request[i]) expected_beats.push_back(beats_for_request[i]);
      end
      @(negedge clock);
   endtask

   // Stop offering, wait for every owed beat, then let the block run on past the bits
   // that can still trail the last beat of a bit put, so that it is surely idle.
   task automatic drain_and_settle();
      req_chan.valid = 1'b0;
      burst_left = 0;
      while (expected_beats.size() != 0) @(negedge clock);
      repeat (12) @(negedge clock);
   endtask

   task automatic write_buffer_length(input logic [15:0] len);
      drain_and_settle();
      csr_write_enable = 1'b1;
      csr_write_data   = len;
      @(negedge clock);
      csr_write_enable = 1'b0;
      buf_len = len;
   endtask

   // Random requests. Most of them are well-formed: value puts of legal widths,
   // and bit-mode sessions (enter, a few bit puts with the odd seek, leave).
   // The rest are seeks and malformed requests. A session is sometimes left
   // open so that later value puts meet bit mode.
   task automatic run_random_phase(input int count);
      logic [3:0] widths [5] = '{4'd1, 4'd2, 4'd3, 4'd4, 4'd8};
      req_type    r;
      int         sent;
      int         kind;
      int         puts;
      int         i;
      sent = 0;
      while (sent < count) begin
         kind = $urandom_range(0, 99);
         if (kind < 30) begin
            r = random_req();
            r.mode = ModePutValue;
            r.byte_count = widths[$urandom_range(0, 4)];
            send_request(r, 1'b0, '0);
            sent++;
         end else if (kind < 55) begin
            r = random_req();
            r.mode = ModeEnterBits;
            send_request(r, 1'b0, '0);
            sent++;
            puts = $urandom_range(1, 6);
            for (i = 0; i < puts; i++) begin
               r = random_req();
               if ($urandom_range(0, 7) == 0) begin
                  r.mode = ModeSeek;
                  r.position = seek_target();
               end else begin
                  r.mode = ModePutBits;
                  r.bit_count = 6'($urandom_range(1, 32));
               end
               send_request(r, 1'b0, '0);
               sent++;
            end
            if ($urandom_range(0, 9) != 0) begin
               r = random_req();
               r.mode = ModeLeaveBits;
               send_request(r, 1'b0, '0);
               sent++;
            end
         end else if (kind < 70) begin
            r = random_req();
            r.mode = ModeSeek;
            r.position = seek_target();
            send_request(r, 1'b0, '0);
            sent++;
         end else begin
            r = random_req();
            case ($urandom_range(0, 3))
               0: r.mode = 3'($urandom_range(ModeFirstUnused, ModeLastUnused));
               1: begin
                  r.mode = ModePutValue;
                  while (r.byte_count inside {4'd1, 4'd2, 4'd3, 4'd4, 4'd8})
                     r.byte_count = 4'($urandom);
               end
               2: begin
                  r.mode = ModePutBits;
                  r.bit_count = ($urandom_range(0, 1) == 0) ? 6'd0
                                                           : 6'($urandom_range(33, 63));
               end
               default: r.mode = 3'($urandom_range(ModePutValue, ModeSeek));
            endcase
            send_request(r, 1'b0, '0);
            sent++;
         end
      end
   endtask

   // ---------------------------------------------------------------------------------
   // Result side
   // ---------------------------------------------------------------------------------

   // The receiver stalls on a pattern of its own: segments of always ready,
   // mostly ready, mostly stalled, and ready one cycle in four. When the
   // stimulus asks for it, it holds ready low for a long stretch, counted here,
   // while the sender keeps offering; the block then fills up and stalls its
   // request channel.
   initial begin : receiver
      int pattern;
      int segment_left;
      int tick;
      rsp_chan.ready = 1'b0;
      pattern = 0;
      segment_left = 0;
      tick = 0;
      forever begin
         @(negedge clock);
         if (hold_off_request) begin
            rsp_chan.ready = 1'b0;
            repeat (200) @(negedge clock);
            hold_off_request = 1'b0;
         end
         if (segment_left == 0) begin
            pattern = $urandom_range(0, 3);
            segment_left = $urandom_range(30, 120);
         end
         segment_left--;
         tick++;
         case (pattern)
            0: rsp_chan.ready = 1'b1;
            1: rsp_chan.ready = ($urandom_range(0, 3) != 0);
            2: rsp_chan.ready = ($urandom_range(0, 3) == 0);
            default: rsp_chan.ready = (tick % 4 == 0);
         endcase
      end
   end

   function automatic void check_field(string name, longint unsigned want,
                                       longint unsigned got);
      if (want != got) begin
         mismatch_count++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
   endfunction

   // Every beat taken from the block is compared with the oldest one owed.
   always @(posedge clock) begin : result_check
      rsp_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (expected_beats.size() == 0) begin
            mismatch_count++;
            $display("%0t: unexpected beat, expected none, actual byte %0h offset %0h",
                     $time, rsp_chan.out_byte, rsp_chan.byte_offset);
         end else begin
            want = expected_beats.pop_front();
            check_field("out_byte", want.out_byte, rsp_chan.out_byte);
            check_field("byte_offset", want.byte_offset, rsp_chan.byte_offset);
            check_field("byte_valid", want.byte_valid, rsp_chan.byte_valid);
            check_field("status", want.status, rsp_chan.status);
            check_field("last", want.last, rsp_chan.last);
         end
      end
   end

   // A hung block or a beat that never comes ends the run here.
   initial begin
      #3000000;
      $display("packet_field_serializer test failed");
      $finish;
   end

   // ---------------------------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------------------------

   initial begin
      req_chan.valid      = 1'b0;
      req_chan.mode       = '0;
      req_chan.value      = '0;
      req_chan.byte_count = '0;
      req_chan.bit_count  = '0;
      req_chan.byte_order = '0;
      req_chan.negate     = 1'b0;
      req_chan.invert_128 = 1'b0;
      req_chan.offset_128 = 1'b0;
      req_chan.position   = '0;
      csr_write_enable    = 1'b0;
      csr_write_data      = '0;
      reset               = 1'b1;
      repeat (4) @(negedge clock);
      reset = 1'b0;

      // Directed table, run with the buffer length left at its reset value.
      // The write position after each row is noted where the typed beats need it.
      add_row(make_req(ModeSeek, 64'd0, 4'd1, 6'd1, OrderBig, 3'b000, 16'd0),
              1'b1, status_beat(16'd0, StatusOk));
      // Widest value, all ones, big order: offsets 0 to 7.
      add_row(make_req(ModePutValue, '1, 4'd8, 6'd1, OrderBig, 3'b000, 16'd0), 1'b0, '0);
      // Negating zero stays zero.
      add_row(make_req(ModePutValue, 64'h0, 4'd1, 6'd1, OrderBig, 3'b100, 16'd0), 1'b0, '0);
      // All three adjustments on 0x80, a byte that negates to itself.
      add_row(make_req(ModePutValue, 64'h80, 4'd1, 6'd1, OrderBig, 3'b111, 16'd0),
              1'b0, '0);
      add_row(make_req(ModePutValue, 64'h1122_3344, 4'd4, 6'd1, OrderMidA, 3'b000, 16'd0),
              1'b0, '0);
      add_row(make_req(ModePutValue, 64'h5566_7788, 4'd4, 6'd1, OrderMidB, 3'b001, 16'd0),
              1'b0, '0);
      add_row(make_req(ModePutValue, 64'hA1_B2C3, 4'd3, 6'd1, OrderLittle, 3'b010, 16'd0),
              1'b0, '0);
      // Middle order on a two-byte value is plain big order.
      add_row(make_req(ModePutValue, 64'hBEEF, 4'd2, 6'd1, OrderMidB, 3'b000, 16'd0),
              1'b0, '0);
      // Little order on one byte changes nothing. Position is now 24.
      add_row(make_req(ModePutValue, 64'h7F, 4'd1, 6'd1, OrderLittle, 3'b110, 16'd0),
              1'b0, '0);
      // Illegal widths, lowest and highest.
      add_row(make_req(ModePutValue, 64'h55, 4'd0, 6'd1, OrderBig, 3'b000, 16'd0),
              1'b1, status_beat(16'd24, StatusBadReq));
      add_row(make_req(ModePutValue, 64'h55, 4'd15, 6'd1, OrderBig, 3'b000, 16'd0),
              1'b1, status_beat(16'd24, StatusBadReq));
      // Bit put outside bit mode, then leaving a bit mode that is not on.
      add_row(make_req(ModePutBits, 64'hFF, 4'd1, 6'd8, OrderBig, 3'b000, 16'd0),
              1'b1, status_beat(16'd24, StatusBadReq));
      add_row(make_req(ModeLeaveBits, 64'd0, 4'd1, 6'd1, OrderBig, 3'b000, 16'd0),
              1'b1, status_beat(16'd24, StatusOk));
      // Enter, then enter again while already on.
      add_row(make_req(ModeEnterBits, 64'd0, 4'd1, 6'd1, OrderBig, 3'b000, 16'd0),
              1'b1, status_beat(16'd24, StatusOk));
      add_row(make_req(ModeEnterBits, 64'd0, 4'd1, 6'd1, OrderBig, 3'b000, 16'd0),
              1'b1, status_beat(16'd24, StatusOk));
      // Value put in bit mode, and bit counts of zero and far above 32.
      add_row(make_req(ModePutValue, 64'h12, 4'd1, 6'd1, OrderBig, 3'b000, 16'd0),
              1'b1, status_beat(16'd24, StatusBadReq));
      add_row(make_req(ModePutBits, 64'h1, 4'd1, 6'd0, OrderBig, 3'b000, 16'd0),
              1'b1, status_beat(16'd24, StatusBadReq));
      add_row(make_req(ModePutBits, '1, 4'd1, 6'd63, OrderBig, 3'b000, 16'd0),
              1'b1, status_beat(16'd24, StatusBadReq));
      // Three bits that complete no byte.
      add_row(make_req(ModePutBits, 64'h5, 4'd1, 6'd3, OrderBig, 3'b000, 16'd0), 1'b0, '0);
      // Seek in bit mode keeps the pending bits, which then land at offset 100.
      add_row(make_req(ModeSeek, 64'd0, 4'd1, 6'd1, OrderBig, 3'b000, 16'd100),
              1'b1, status_beat(16'd100, StatusOk));
      add_row(make_req(ModePutBits, 64'hFFFF_FFFF, 4'd1, 6'd32, OrderBig, 3'b000, 16'd0),
              1'b0, '0);
      // Seek to the very end of the buffer, which is still allowed.
      add_row(make_req(ModeSeek, 64'd0, 4'd1, 6'd1, OrderBig, 3'b000, 16'hFFFF),
              1'b1, status_beat(16'hFFFF, StatusOk));
      // No room for the bits, nor for the pending partial byte on leaving.
      add_row(make_req(ModePutBits, 64'hA5, 4'd1, 6'd8, OrderBig, 3'b000, 16'd0),
              1'b1, status_beat(16'hFFFF, StatusNoRoom));
      add_row(make_req(ModeLeaveBits, 64'd0, 4'd1, 6'd1, OrderBig, 3'b000, 16'd0),
              1'b1, status_beat(16'hFFFF, StatusNoRoom));
      add_row(make_req(ModePutValue, 64'h1, 4'd1, 6'd1, OrderBig, 3'b000, 16'd0),
              1'b1, status_beat(16'hFFFF, StatusNoRoom));
      add_row(make_req(ModeLastUnused, '1, 4'd15, 6'd63, OrderMidB, 3'b111, 16'hFFFF),
              1'b1, status_beat(16'hFFFF, StatusBadReq));

      foreach (directed_rows[i])
         send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].beat);

      // The first random phase opens with the long receiver hold-off.
      hold_off_request = 1'b1;
      run_random_phase(110);

      // An empty buffer: no put finds room, and seeks succeed only to zero.
      write_buffer_length(16'd0);
      run_random_phase(20);

      write_buffer_length(16'd40);
      run_random_phase(70);

      write_buffer_length(16'd1);
      run_random_phase(25);

      write_buffer_length(16'($urandom_range(8, 3000)));
      run_random_phase(70);

      write_buffer_length(16'hFFFF);
      run_random_phase(65);

      drain_and_settle();
      if (mismatch_count == 0) begin
         $display("packet_field_serializer test passed");
      end else begin
         $display("packet_field_serializer test failed");
      end
      $finish;
   end

endmodule
